// File: design/tivs_pkg.sv
// ----------------------------------------------------------------------------
// tivs_pkg: shared types and constants of the tire inflation valve sequencer
// Beat payloads, configuration bundle, command codes, phase states.
// ----------------------------------------------------------------------------
package tivs_pkg;

  localparam int PRESS_W    = 12;
  localparam int TICKS_W    = 16;
  localparam int FILL_CNT_W = TICKS_W + 1;   // holds fill_duration + 1
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PHASE_W    = 3;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_ENABLE  = 2'd1,
    FUNC_DISABLE = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_PRESSURE     = 3'd0,
    REG_VERY_LOW_MARGIN     = 3'd1,
    REG_LOW_MARGIN          = 3'd2,
    REG_SLIGHT_MARGIN       = 3'd3,
    REG_FILL_TICKS_VERY_LOW = 3'd4,
    REG_FILL_TICKS_LOW      = 3'd5,
    REG_FILL_TICKS_SLIGHT   = 3'd6,
    REG_FILL_TICKS_MIN      = 3'd7
  } reg_idx_t;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_CLOSING  = 6'b000010,
    PH_CHECKING = 6'b000100,
    PH_OPENING  = 6'b001000,
    PH_FILLING  = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_t;

  localparam logic [PHASE_W-1:0] PHASE_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_CLOSING  = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_CHECKING = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_OPENING  = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_FILLING  = 3'd4;
  localparam logic [PHASE_W-1:0] PHASE_DONE     = 3'd5;

  typedef struct packed {
    logic [1:0]         func;
    logic [PRESS_W-1:0] pressure_sample;
  } item_t;

  typedef struct packed {
    logic               valve_open;
    logic [PHASE_W-1:0] phase;
    logic               display_strobe;
    logic               filled;
    logic               enabled;
    logic [PRESS_W-1:0] latched_pressure;
  } result_t;

  typedef struct packed {
    logic [PRESS_W-1:0] target_pressure;
    logic [PRESS_W-1:0] very_low_margin;
    logic [PRESS_W-1:0] low_margin;
    logic [PRESS_W-1:0] slight_margin;
    logic [TICKS_W-1:0] fill_ticks_very_low;
    logic [TICKS_W-1:0] fill_ticks_low;
    logic [TICKS_W-1:0] fill_ticks_slight;
    logic [TICKS_W-1:0] fill_ticks_min;
  } cfg_t;

  function automatic logic [PHASE_W-1:0] phase_code(phase_t ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_IDLE:     code = PHASE_IDLE;
      PH_CLOSING:  code = PHASE_CLOSING;
      PH_CHECKING: code = PHASE_CHECKING;
      PH_OPENING:  code = PHASE_OPENING;
      PH_FILLING:  code = PHASE_FILLING;
      PH_DONE:     code = PHASE_DONE;
      default:     code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: design/tivs_cfg.sv
// ----------------------------------------------------------------------------
// tivs_cfg: configuration register file
// Eight thresholds and fill durations, written one beat at a time.
// ----------------------------------------------------------------------------
module tivs_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tivs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tivs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tivs_pkg::cfg_t                    cfg
);

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_pressure     <= 12'd560;
      cfg.very_low_margin     <= 12'd160;
      cfg.low_margin          <= 12'd80;
      cfg.slight_margin       <= 12'd32;
      cfg.fill_ticks_very_low <= 16'd200;
      cfg.fill_ticks_low      <= 16'd100;
      cfg.fill_ticks_slight   <= 16'd50;
      cfg.fill_ticks_min      <= 16'd10;
    end else if (wr) begin
      unique case (tivs_pkg::reg_idx_t'(cfg_index))
        tivs_pkg::REG_TARGET_PRESSURE:
          cfg.target_pressure <= cfg_data[tivs_pkg::PRESS_W-1:0];
        tivs_pkg::REG_VERY_LOW_MARGIN:
          cfg.very_low_margin <= cfg_data[tivs_pkg::PRESS_W-1:0];
        tivs_pkg::REG_LOW_MARGIN:
          cfg.low_margin <= cfg_data[tivs_pkg::PRESS_W-1:0];
        tivs_pkg::REG_SLIGHT_MARGIN:
          cfg.slight_margin <= cfg_data[tivs_pkg::PRESS_W-1:0];
        tivs_pkg::REG_FILL_TICKS_VERY_LOW:
          cfg.fill_ticks_very_low <= cfg_data[tivs_pkg::TICKS_W-1:0];
        tivs_pkg::REG_FILL_TICKS_LOW:
          cfg.fill_ticks_low <= cfg_data[tivs_pkg::TICKS_W-1:0];
        tivs_pkg::REG_FILL_TICKS_SLIGHT:
          cfg.fill_ticks_slight <= cfg_data[tivs_pkg::TICKS_W-1:0];
        tivs_pkg::REG_FILL_TICKS_MIN:
          cfg.fill_ticks_min <= cfg_data[tivs_pkg::TICKS_W-1:0];
      endcase
    end
  end

endmodule

// File: design/tivs_seq.sv
// ----------------------------------------------------------------------------
// tivs_seq: valve sequencer state and next-state logic
// Holds the phase machine and its counters; updates them on each step.
// ----------------------------------------------------------------------------
module tivs_seq #(
  parameter int VALVE_DELAY    = 2,
  parameter int READ_DELAY     = 1,
  parameter int DISPLAY_PERIOD = 20,
  parameter int PRESSURE_BITS  = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tivs_pkg::item_t   item,
  input  tivs_pkg::cfg_t    cfg,
  output tivs_pkg::result_t result
);

  localparam int VD_W = $clog2(VALVE_DELAY + 2);
  localparam int RD_W = $clog2(READ_DELAY + 2);
  localparam int DP_W = (DISPLAY_PERIOD > 1) ? $clog2(DISPLAY_PERIOD) : 1;
  localparam int PW   = tivs_pkg::PRESS_W;
  localparam int FW   = tivs_pkg::FILL_CNT_W;
  localparam logic [VD_W-1:0] VD_LIMIT  = VD_W'(VALVE_DELAY);
  localparam logic [RD_W-1:0] RD_LIMIT  = RD_W'(READ_DELAY);
  localparam logic [DP_W-1:0] DP_LAST   = DP_W'(DISPLAY_PERIOD - 1);
  localparam logic [PW-1:0]   PMASK     = (PRESSURE_BITS >= PW) ? {PW{1'b1}} :
                                          PW'((32'd1 << PRESSURE_BITS) - 32'd1);

  tivs_pkg::phase_t                 phase, phase_next;
  logic                             enable_flag, enable_flag_next;
  logic                             valve_open, valve_open_next;
  logic [VD_W-1:0]                  valve_delay_count, valve_delay_count_next;
  logic [RD_W-1:0]                  read_delay_count, read_delay_count_next;
  logic [PW-1:0]                    pressure_hold, pressure_hold_next;
  logic [tivs_pkg::TICKS_W-1:0]     fill_duration, fill_duration_next;
  logic [FW-1:0]                    fill_count, fill_count_next;
  logic [DP_W-1:0]                  display_count, display_count_next;
  logic [PW-1:0]                    shortfall;
  logic [tivs_pkg::TICKS_W-1:0]     fill_pick;
  logic                             strobe, filled;

  assign shortfall = cfg.target_pressure - pressure_hold;

  always_comb begin
    priority if (shortfall > cfg.very_low_margin) begin
      fill_pick = cfg.fill_ticks_very_low;
    end else if (shortfall > cfg.low_margin) begin
      fill_pick = cfg.fill_ticks_low;
    end else if (shortfall > cfg.slight_margin) begin
      fill_pick = cfg.fill_ticks_slight;
    end else begin
      fill_pick = cfg.fill_ticks_min;
    end
  end

  always_comb begin
    phase_next             = phase;
    enable_flag_next       = enable_flag;
    valve_open_next        = valve_open;
    valve_delay_count_next = valve_delay_count;
    read_delay_count_next  = read_delay_count;
    pressure_hold_next     = pressure_hold;
    fill_duration_next     = fill_duration;
    fill_count_next        = fill_count;
    display_count_next     = display_count;
    strobe                 = 1'b0;
    filled                 = 1'b0;
    unique case (tivs_pkg::func_t'(item.func))
      tivs_pkg::FUNC_TICK: begin
        if (phase != tivs_pkg::PH_IDLE && !enable_flag) begin
          // disabled while active: drop to idle, keep valve and counters
          phase_next = tivs_pkg::PH_IDLE;
        end else begin
          unique case (phase)
            tivs_pkg::PH_IDLE: begin
              if (enable_flag) begin
                valve_delay_count_next = '0;
                phase_next             = tivs_pkg::PH_CLOSING;
              end
            end
            tivs_pkg::PH_CLOSING: begin
              valve_open_next = 1'b0;
              if (valve_delay_count > VD_LIMIT) begin
                valve_delay_count_next = '0;
                phase_next             = tivs_pkg::PH_CHECKING;
              end else begin
                valve_delay_count_next = valve_delay_count + 1'b1;
              end
            end
            tivs_pkg::PH_CHECKING: begin
              if (read_delay_count == '0) begin
                pressure_hold_next    = item.pressure_sample & PMASK;
                read_delay_count_next = RD_W'(1);
              end else if (read_delay_count > RD_LIMIT) begin
                read_delay_count_next = '0;
                if (pressure_hold >= cfg.target_pressure) begin
                  phase_next = tivs_pkg::PH_DONE;
                end else begin
                  fill_duration_next = fill_pick;
                  strobe             = 1'b1;
                  phase_next         = tivs_pkg::PH_OPENING;
                end
              end else begin
                read_delay_count_next = read_delay_count + 1'b1;
              end
            end
            tivs_pkg::PH_OPENING: begin
              valve_open_next = 1'b1;
              if (valve_delay_count > VD_LIMIT) begin
                valve_delay_count_next = '0;
                phase_next             = tivs_pkg::PH_FILLING;
              end else begin
                valve_delay_count_next = valve_delay_count + 1'b1;
              end
            end
            tivs_pkg::PH_FILLING: begin
              if (fill_count > {1'b0, fill_duration}) begin
                fill_count_next    = '0;
                display_count_next = '0;
                phase_next         = tivs_pkg::PH_CLOSING;
              end else begin
                fill_count_next = fill_count + 1'b1;
                // display_count tracks fill_count modulo the display period
                if (display_count == DP_LAST) begin
                  display_count_next = '0;
                  strobe             = 1'b1;
                end else begin
                  display_count_next = display_count + 1'b1;
                end
              end
            end
            tivs_pkg::PH_DONE: begin
              strobe           = 1'b1;
              filled           = 1'b1;
              enable_flag_next = 1'b0;
              phase_next       = tivs_pkg::PH_IDLE;
            end
            default: begin
              phase_next = tivs_pkg::PH_IDLE;
            end
          endcase
        end
      end
      tivs_pkg::FUNC_ENABLE:  enable_flag_next = 1'b1;
      tivs_pkg::FUNC_DISABLE: enable_flag_next = 1'b0;
      tivs_pkg::FUNC_NOP: ;
    endcase
  end

  always_comb begin
    result.valve_open       = valve_open_next;
    result.phase            = tivs_pkg::phase_code(phase_next);
    result.display_strobe   = strobe;
    result.filled           = filled;
    result.enabled          = enable_flag_next;
    result.latched_pressure = pressure_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= tivs_pkg::PH_IDLE;
      enable_flag       <= 1'b0;
      valve_open        <= 1'b0;
      valve_delay_count <= '0;
      read_delay_count  <= '0;
      pressure_hold     <= '0;
      fill_duration     <= '0;
      fill_count        <= '0;
      display_count     <= '0;
    end else if (step) begin
      phase             <= phase_next;
      enable_flag       <= enable_flag_next;
      valve_open        <= valve_open_next;
      valve_delay_count <= valve_delay_count_next;
      read_delay_count  <= read_delay_count_next;
      pressure_hold     <= pressure_hold_next;
      fill_duration     <= fill_duration_next;
      fill_count        <= fill_count_next;
      display_count     <= display_count_next;
    end
  end

  a_valve_delay_bound: assert property (@(posedge clk) disable iff (rst)
    valve_delay_count <= VD_LIMIT + 1'b1)
    else $error("valve delay count past its limit");

  a_read_delay_bound: assert property (@(posedge clk) disable iff (rst)
    read_delay_count <= RD_LIMIT + 1'b1)
    else $error("read delay count past its limit");

  a_display_bound: assert property (@(posedge clk) disable iff (rst)
    display_count <= DP_LAST)
    else $error("display count past the period");

  a_done_clears_enable: assert property (@(posedge clk) disable iff (rst)
    step && phase == tivs_pkg::PH_DONE && enable_flag &&
    item.func == tivs_pkg::FUNC_TICK |=> !enable_flag && phase == tivs_pkg::PH_IDLE)
    else $error("done tick did not clear enable and return to idle");

endmodule

// File: design/tire_inflation_valve_sequencer.sv
// ----------------------------------------------------------------------------
// tire_inflation_valve_sequencer: top level
// Input register, sequencer step, result register, configuration registers.
// ----------------------------------------------------------------------------
//   channel   handshake               payload
//   item      item_valid/item_stall   item (func, pressure_sample)
//   result    result_valid/result_stall result (valve, phase, pulses, pressure)
//   cfg       cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One item per cycle when the result is not stalled; each item goes through the input
// register, then one pass of the phase logic into the result register.
// Reset (rst, synchronous) returns the phase machine to idle, the counters to
// zero and the configuration registers to their defaults; cfg_ready is always high.
// A stalled result holds the pipe; item_stall rises only when the input
// register is full and cannot move on.
// ----------------------------------------------------------------------------
module tire_inflation_valve_sequencer #(
  parameter int VALVE_DELAY    = 2,
  parameter int READ_DELAY     = 1,
  parameter int DISPLAY_PERIOD = 20,
  parameter int PRESSURE_BITS  = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  tivs_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output tivs_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tivs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tivs_pkg::CFG_DATA_W-1:0] cfg_data
);

  tivs_pkg::item_t   item_q;
  logic              item_q_valid;
  logic              advance;
  tivs_pkg::cfg_t    cfg;
  tivs_pkg::result_t step_result;

  assign advance    = item_q_valid && (!result_valid || !result_stall);
  assign item_stall = item_q_valid && !advance;

  tivs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tivs_seq #(
    .VALVE_DELAY    (VALVE_DELAY),
    .READ_DELAY     (READ_DELAY),
    .DISPLAY_PERIOD (DISPLAY_PERIOD),
    .PRESSURE_BITS  (PRESSURE_BITS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q <= '0;
    end else if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  a_step_gives_beat: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("stepped item produced no result beat");

  a_filled_state: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.filled |->
      result.display_strobe && !result.enabled && result.phase == tivs_pkg::PHASE_IDLE)
    else $error("filled pulse with inconsistent state");

  a_filling_valve_open: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.phase == tivs_pkg::PHASE_FILLING |-> result.valve_open)
    else $error("filling phase with the valve closed");

endmodule
